[design/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PRRS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, checked outside reset.
`define PRRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

[design/prrs_pkg.sv]
// Types and codes shared by the scheduler modules.
package prrs_pkg;

    typedef enum logic [2:0] {
        ACT_CREATE   = 3'd0,
        ACT_DELETE   = 3'd1,
        ACT_BLOCK    = 3'd2,
        ACT_UNBLOCK  = 3'd3,
        ACT_SCHEDULE = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] task_id;
        logic [4:0] task_priority;
    } t_cmd_item;

    typedef struct packed {
        logic [3:0] running_task;
        logic [3:0] previous_task;
        logic       switched;
        logic       to_idle;
        logic       status;
    } t_res_item;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_FAIL,
        ST_CR1, ST_CR2,
        ST_UB1, ST_UB2, ST_UB3,
        ST_INS0, ST_INS1, ST_INS2, ST_INS3,
        ST_RM0, ST_RM1, ST_RM2,
        ST_SC0, ST_SC1, ST_SRCH, ST_SC2, ST_SC3,
        ST_CM0, ST_CM1,
        ST_LOAD
    } t_state;

    typedef enum logic [4:0] {
        OP_IDLE, OP_DECODE, OP_FAIL,
        OP_CR1, OP_CR2,
        OP_UB1, OP_UB2, OP_UB3,
        OP_INS0, OP_INS1, OP_INS2, OP_INS3,
        OP_RM0, OP_RM1, OP_RM2,
        OP_SC0, OP_SC1, OP_SRCH, OP_SC2, OP_SC3,
        OP_CM0, OP_CM1,
        OP_LOAD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        t_action act;
        logic    bad_create;
        logic    bad_delete;
        logic    bad_block;
        logic    bad_unblock;
        logic    id_ready;
        logic    cur_is_id;
        logic    cur_valid;
        logic    resel;
        logic    lv_nonempty;
        logic    succ_ok;
        logic    found;
        logic    out_free;
    } t_sts;

endpackage

[design/prrs_chan_if.sv]
// Valid/ready channel carrying one item of a given payload type.
interface prrs_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/prrs_ctrl.sv]
// Sequencer that steps the datapath through each scheduler action.
module prrs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  prrs_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output prrs_pkg::t_ctl  o_ctl
);

    prrs_pkg::t_state r_state;
    prrs_pkg::t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prrs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pick the next step and the datapath op
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctl.op   = prrs_pkg::OP_IDLE;
        unique case (r_state)
            prrs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.op   = prrs_pkg::OP_IDLE;
                if (i_in_valid) n_state = prrs_pkg::ST_DECODE;
            end
            prrs_pkg::ST_DECODE: begin
                o_ctl.op = prrs_pkg::OP_DECODE;
                case (i_sts.act)
                    prrs_pkg::ACT_CREATE:
                        n_state = i_sts.bad_create ? prrs_pkg::ST_FAIL : prrs_pkg::ST_CR1;
                    prrs_pkg::ACT_DELETE: begin
                        if (i_sts.bad_delete)     n_state = prrs_pkg::ST_FAIL;
                        else if (i_sts.id_ready)  n_state = prrs_pkg::ST_RM0;
                        else if (i_sts.cur_is_id) n_state = prrs_pkg::ST_SC0;
                        else                      n_state = prrs_pkg::ST_LOAD;
                    end
                    prrs_pkg::ACT_BLOCK:
                        n_state = i_sts.bad_block ? prrs_pkg::ST_FAIL : prrs_pkg::ST_RM0;
                    prrs_pkg::ACT_UNBLOCK:
                        n_state = i_sts.bad_unblock ? prrs_pkg::ST_FAIL : prrs_pkg::ST_UB1;
                    prrs_pkg::ACT_SCHEDULE:
                        n_state = prrs_pkg::ST_SC0;
                    default:
                        n_state = prrs_pkg::ST_FAIL;
                endcase
            end
            prrs_pkg::ST_FAIL: begin
                o_ctl.op = prrs_pkg::OP_FAIL;
                n_state  = prrs_pkg::ST_LOAD;
            end
            prrs_pkg::ST_CR1: begin
                o_ctl.op = prrs_pkg::OP_CR1;
                n_state  = prrs_pkg::ST_CR2;
            end
            prrs_pkg::ST_CR2: begin
                o_ctl.op = prrs_pkg::OP_CR2;
                n_state  = prrs_pkg::ST_INS0;
            end
            prrs_pkg::ST_UB1: begin
                o_ctl.op = prrs_pkg::OP_UB1;
                n_state  = prrs_pkg::ST_UB2;
            end
            prrs_pkg::ST_UB2: begin
                o_ctl.op = prrs_pkg::OP_UB2;
                n_state  = prrs_pkg::ST_UB3;
            end
            prrs_pkg::ST_UB3: begin
                o_ctl.op = prrs_pkg::OP_UB3;
                n_state  = prrs_pkg::ST_INS0;
            end
            prrs_pkg::ST_INS0: begin
                o_ctl.op = prrs_pkg::OP_INS0;
                n_state  = i_sts.lv_nonempty ? prrs_pkg::ST_INS1 : prrs_pkg::ST_LOAD;
            end
            prrs_pkg::ST_INS1: begin
                o_ctl.op = prrs_pkg::OP_INS1;
                n_state  = prrs_pkg::ST_INS2;
            end
            prrs_pkg::ST_INS2: begin
                o_ctl.op = prrs_pkg::OP_INS2;
                n_state  = prrs_pkg::ST_INS3;
            end
            prrs_pkg::ST_INS3: begin
                o_ctl.op = prrs_pkg::OP_INS3;
                n_state  = prrs_pkg::ST_LOAD;
            end
            prrs_pkg::ST_RM0: begin
                o_ctl.op = prrs_pkg::OP_RM0;
                n_state  = prrs_pkg::ST_RM1;
            end
            prrs_pkg::ST_RM1: begin
                o_ctl.op = prrs_pkg::OP_RM1;
                n_state  = prrs_pkg::ST_RM2;
            end
            prrs_pkg::ST_RM2: begin
                o_ctl.op = prrs_pkg::OP_RM2;
                if (i_sts.act == prrs_pkg::ACT_BLOCK || i_sts.cur_is_id)
                    n_state = prrs_pkg::ST_SC0;
                else
                    n_state = prrs_pkg::ST_LOAD;
            end
            prrs_pkg::ST_SC0: begin
                o_ctl.op = prrs_pkg::OP_SC0;
                n_state  = (!i_sts.resel && i_sts.cur_valid) ? prrs_pkg::ST_SC1
                                                              : prrs_pkg::ST_SRCH;
            end
            prrs_pkg::ST_SC1: begin
                o_ctl.op = prrs_pkg::OP_SC1;
                n_state  = i_sts.succ_ok ? prrs_pkg::ST_CM0 : prrs_pkg::ST_SRCH;
            end
            prrs_pkg::ST_SRCH: begin
                o_ctl.op = prrs_pkg::OP_SRCH;
                n_state  = i_sts.found ? prrs_pkg::ST_SC2 : prrs_pkg::ST_LOAD;
            end
            prrs_pkg::ST_SC2: begin
                o_ctl.op = prrs_pkg::OP_SC2;
                n_state  = prrs_pkg::ST_SC3;
            end
            prrs_pkg::ST_SC3: begin
                o_ctl.op = prrs_pkg::OP_SC3;
                n_state  = prrs_pkg::ST_CM0;
            end
            prrs_pkg::ST_CM0: begin
                o_ctl.op = prrs_pkg::OP_CM0;
                n_state  = prrs_pkg::ST_CM1;
            end
            prrs_pkg::ST_CM1: begin
                o_ctl.op = prrs_pkg::OP_CM1;
                n_state  = prrs_pkg::ST_LOAD;
            end
            prrs_pkg::ST_LOAD: begin
                o_ctl.op = prrs_pkg::OP_LOAD;
                if (i_sts.out_free) n_state = prrs_pkg::ST_IDLE;
            end
            default: n_state = prrs_pkg::ST_IDLE;
        endcase
    end

endmodule

[design/prrs_datapath.sv]
// Link memories, ready flags and the current-task registers of the scheduler.
module prrs_datapath #(
    parameter int MAX_TASKS  = 16,
    parameter int NUM_LEVELS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prrs_pkg::t_ctl      i_ctl,
    input  logic                i_in_fire,
    input  prrs_pkg::t_cmd_item i_in_item,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output prrs_pkg::t_res_item o_out_item,
    output prrs_pkg::t_sts      o_sts
);

    localparam int TW = $clog2(MAX_TASKS);
    localparam int LW = $clog2(NUM_LEVELS);

    // Link and level memories
    logic [TW-1:0] mem_succ [MAX_TASKS];
    logic [TW-1:0] mem_pred [MAX_TASKS];
    logic [LW-1:0] mem_prio [MAX_TASKS];
    logic [TW-1:0] mem_last [NUM_LEVELS];

    logic [TW-1:0] r_succ_q, r_pred_q, r_last_q;
    logic [LW-1:0] r_prio_q;

    // Flags and control registers
    logic [MAX_TASKS-1:0]  r_used, r_ready;
    logic [NUM_LEVELS-1:0] r_nonempty;
    logic                  r_cur_valid, r_resel, r_out_valid;

    // Item registers
    prrs_pkg::t_action     r_act;
    logic [3:0]            r_id_raw;
    logic [4:0]            r_pr_raw;
    logic [TW-1:0]         r_cur, r_prev, r_t, r_a, r_h, r_pv, r_n;
    logic [LW-1:0]         r_lv;
    logic                  r_prev_valid, r_sw, r_idle, r_status;
    prrs_pkg::t_res_item   r_out;

    logic          id_ok, pr_ok, found, sw_now, out_free;
    logic [TW-1:0] id_idx;
    logic [LW-1:0] pr_idx, enc;

    logic [TW-1:0] succ_ra, pred_ra, succ_wa, succ_wd, pred_wa, pred_wd;
    logic [TW-1:0] prio_ra, last_wd;
    logic [LW-1:0] last_ra, last_wa;
    logic          succ_we, pred_we, prio_we, last_we;

    assign id_ok    = 32'(r_id_raw) < MAX_TASKS;
    assign pr_ok    = 32'(r_pr_raw) < NUM_LEVELS;
    assign id_idx   = TW'(r_id_raw);
    assign pr_idx   = LW'(r_pr_raw);
    assign out_free = !r_out_valid || i_out_ready;
    assign sw_now   = !r_prev_valid || (r_n != r_prev);

    // Find the highest non-empty level
    always_comb begin
        enc   = '0;
        found = 1'b0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (r_nonempty[i]) begin
                enc   = LW'(i);
                found = 1'b1;
            end
        end
    end

    // Drive status toward the sequencer
    always_comb begin
        o_sts.act         = r_act;
        o_sts.bad_create  = !id_ok || !pr_ok || r_used[id_idx];
        o_sts.bad_delete  = !id_ok || !r_used[id_idx];
        o_sts.bad_unblock = !id_ok || !r_used[id_idx] || r_ready[id_idx];
        o_sts.bad_block   = !r_cur_valid || !r_ready[r_cur];
        o_sts.id_ready    = r_ready[id_idx];
        o_sts.cur_is_id   = r_cur_valid && (r_cur == id_idx) && id_ok;
        o_sts.cur_valid   = r_cur_valid;
        o_sts.resel       = r_resel;
        o_sts.lv_nonempty = r_nonempty[r_lv];
        o_sts.succ_ok     = r_used[r_succ_q] && r_ready[r_succ_q];
        o_sts.found       = found;
        o_sts.out_free    = out_free;
    end

    // Select memory addresses and writes for this step
    always_comb begin
        succ_ra = r_t;
        pred_ra = r_t;
        prio_ra = r_t;
        last_ra = r_lv;
        succ_we = 1'b0; succ_wa = r_t; succ_wd = r_t;
        pred_we = 1'b0; pred_wa = r_t; pred_wd = r_t;
        prio_we = 1'b0;
        last_we = 1'b0; last_wa = r_lv; last_wd = r_t;
        case (i_ctl.op)
            prrs_pkg::OP_CR1: begin
                prio_ra = r_cur;
                prio_we = 1'b1;
            end
            prrs_pkg::OP_UB1: prio_ra = id_idx;
            prrs_pkg::OP_UB2: prio_ra = r_cur;
            prrs_pkg::OP_INS0: begin
                if (!r_nonempty[r_lv]) begin
                    succ_we = 1'b1;
                    pred_we = 1'b1;
                    last_we = 1'b1;
                end
            end
            prrs_pkg::OP_INS1: pred_ra = r_last_q;
            prrs_pkg::OP_INS2: begin
                succ_we = 1'b1; succ_wd = r_h;
                pred_we = 1'b1; pred_wd = r_pred_q;
            end
            prrs_pkg::OP_INS3: begin
                succ_we = 1'b1; succ_wa = r_pv;
                pred_we = 1'b1; pred_wa = r_h;
            end
            prrs_pkg::OP_RM1: begin
                succ_we = 1'b1; succ_wa = r_pred_q; succ_wd = r_succ_q;
                pred_we = 1'b1; pred_wa = r_succ_q; pred_wd = r_pred_q;
                last_ra = r_prio_q;
            end
            prrs_pkg::OP_RM2: begin
                if (r_a != r_t && r_last_q == r_t) begin
                    last_we = 1'b1;
                    last_wd = r_a;
                end
            end
            prrs_pkg::OP_SC0:  succ_ra = r_cur;
            prrs_pkg::OP_SRCH: last_ra = enc;
            prrs_pkg::OP_SC2:  succ_ra = r_last_q;
            prrs_pkg::OP_CM0:  prio_ra = r_n;
            prrs_pkg::OP_CM1: begin
                last_we = 1'b1;
                last_wa = r_prio_q;
                last_wd = r_n;
            end
            default: ;
        endcase
    end

    // Write and read the memories
    always_ff @(posedge i_clk) begin
        if (succ_we) mem_succ[succ_wa] <= succ_wd;
        if (pred_we) mem_pred[pred_wa] <= pred_wd;
        if (prio_we) mem_prio[id_idx]  <= pr_idx;
        if (last_we) mem_last[last_wa] <= last_wd;
        r_succ_q <= mem_succ[succ_ra];
        r_pred_q <= mem_pred[pred_ra];
        r_prio_q <= mem_prio[prio_ra];
        r_last_q <= mem_last[last_ra];
    end

    // Update flags and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_ready     <= '0;
            r_nonempty  <= '0;
            r_cur_valid <= 1'b0;
            r_resel     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the sent result unless a new one loads this cycle
            if (r_out_valid && i_out_ready && i_ctl.op != prrs_pkg::OP_LOAD)
                r_out_valid <= 1'b0;
            case (i_ctl.op)
                prrs_pkg::OP_DECODE: begin
                    if (r_act == prrs_pkg::ACT_DELETE && !o_sts.bad_delete)
                        r_used[id_idx] <= 1'b0;
                end
                prrs_pkg::OP_CR1: begin
                    r_used[id_idx] <= 1'b1;
                    if (!r_cur_valid) r_cur_valid <= 1'b1;
                end
                prrs_pkg::OP_CR2: begin
                    if (r_prev_valid && (r_lv > r_prio_q)) r_resel <= 1'b1;
                end
                prrs_pkg::OP_UB3: begin
                    if (!r_cur_valid || (r_lv > r_prio_q)) r_resel <= 1'b1;
                end
                prrs_pkg::OP_INS0: begin
                    if (!r_nonempty[r_lv]) begin
                        r_nonempty[r_lv] <= 1'b1;
                        r_ready[r_t]     <= 1'b1;
                    end
                end
                prrs_pkg::OP_INS3: r_ready[r_t] <= 1'b1;
                prrs_pkg::OP_RM1:  r_ready[r_t] <= 1'b0;
                prrs_pkg::OP_RM2: begin
                    if (r_a == r_t) begin
                        r_nonempty[r_lv] <= 1'b0;
                        r_resel          <= 1'b1;
                    end
                end
                prrs_pkg::OP_SRCH: begin
                    r_resel <= 1'b0;
                    if (!found) r_cur_valid <= 1'b0;
                end
                prrs_pkg::OP_CM0: r_cur_valid <= 1'b1;
                prrs_pkg::OP_LOAD: begin
                    if (out_free) r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Update item registers
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_act        <= prrs_pkg::t_action'(i_in_item.action);
            r_id_raw     <= i_in_item.task_id;
            r_pr_raw     <= i_in_item.task_priority;
            r_prev       <= r_cur;
            r_prev_valid <= r_cur_valid;
            r_sw         <= 1'b0;
            r_idle       <= 1'b0;
            r_status     <= 1'b0;
        end
        case (i_ctl.op)
            prrs_pkg::OP_DECODE: begin
                r_t  <= (r_act == prrs_pkg::ACT_BLOCK) ? r_cur : id_idx;
                r_lv <= pr_idx;
            end
            prrs_pkg::OP_FAIL: r_status <= 1'b1;
            prrs_pkg::OP_CR1:  if (!r_cur_valid) r_cur <= id_idx;
            prrs_pkg::OP_UB2:  r_lv <= r_prio_q;
            prrs_pkg::OP_INS1: r_h  <= r_last_q;
            prrs_pkg::OP_INS2: r_pv <= r_pred_q;
            prrs_pkg::OP_RM1: begin
                r_lv <= r_prio_q;
                r_a  <= r_pred_q;
            end
            prrs_pkg::OP_SC1:  r_n <= r_succ_q;
            prrs_pkg::OP_SRCH: if (!found) r_status <= 1'b1;
            prrs_pkg::OP_SC3:  r_n <= r_succ_q;
            prrs_pkg::OP_CM0:  r_cur <= r_n;
            prrs_pkg::OP_CM1: begin
                r_sw   <= sw_now;
                r_idle <= sw_now && (r_prio_q == '0);
            end
            prrs_pkg::OP_LOAD: begin
                if (out_free) begin
                    r_out.running_task  <= r_cur_valid ? 4'(r_cur) : 4'd0;
                    r_out.previous_task <= r_prev_valid ? 4'(r_prev) : 4'd0;
                    r_out.switched      <= r_sw;
                    r_out.to_idle       <= r_idle;
                    r_out.status        <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[design/priority_round_robin_scheduler.sv]
// Priority round-robin ready-queue scheduler, top level.
//
// Usage: actions arrive on i_cmd (create, delete, block current, unblock,
// schedule tick) with task_id and task_priority; each action yields exactly
// one result item on o_res with the running task, the previous task, the
// switched and to_idle flags and a reject status.
// Sequence: each action ends in LOAD, which loads its result. From DECODE
// a rejected action passes FAIL; a create CR1 and CR2 and an unblock UB1
// to UB3, both then linking the task in INS0 (INS1 to INS3 when the level
// holds tasks); a block or a delete of a ready task unlinks it in RM0 to
// RM2; a schedule runs SC0 to CM1 with the level search, one read per step.
// Throughput: one action at a time; i_cmd.ready rises again as soon as the
// result sits in the output register, so the next action is taken while a
// result still waits.
// Reset: all tasks are unused, no level holds a task and there is no
// current task. Link and level memories need no clearing pass.
// Stall: when o_res is held off, the finished result stays in the output
// register and a following result waits in the sequencer until it frees.
module priority_round_robin_scheduler #(
    parameter int MAX_TASKS  = 16,
    parameter int NUM_LEVELS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prrs_chan_if.sink   i_cmd,
    prrs_chan_if.source o_res
);

`include "assert_macros.svh"

    prrs_pkg::t_ctl      ctl;
    prrs_pkg::t_sts      sts;
    prrs_pkg::t_res_item res_item;
    logic                in_ready, in_fire, out_valid;

    assign i_cmd.ready = in_ready;
    assign in_fire     = i_cmd.valid && in_ready;
    assign o_res.valid = out_valid;
    assign o_res.data  = res_item;

    // Sequencer
    prrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_ctl      (ctl)
    );

    // Storage and task registers
    prrs_datapath #(
        .MAX_TASKS  (MAX_TASKS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_fire   (in_fire),
        .i_in_item   (i_cmd.data),
        .i_out_ready (o_res.ready),
        .o_out_valid (out_valid),
        .o_out_item  (res_item),
        .o_sts       (sts)
    );

    // Check sequencing and result consistency
    `PRRS_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
    `PRRS_ASSERT_IMPL(a_idle_needs_switch, out_valid && !res_item.switched, !res_item.to_idle)
    `PRRS_ASSERT_IMPL(a_reject_no_switch, out_valid && res_item.status, !res_item.switched)

endmodule

[tb/testbench.sv]
// Testbench for the priority round-robin scheduler: random actions, predicted results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTASK = 16;
    localparam int NLVL  = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    prrs_chan_if #(.t_payload(prrs_pkg::t_cmd_item)) cmd_if ();
    prrs_chan_if #(.t_payload(prrs_pkg::t_res_item)) res_if ();

    priority_round_robin_scheduler u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    // Predictor state
    logic [3:0] nxt_link [NTASK];
    logic [3:0] prv_link [NTASK];
    logic [4:0] task_lvl [NTASK];
    logic       is_ready [NTASK];
    logic       is_used  [NTASK];
    logic [3:0] lvl_last [NLVL];
    logic       lvl_busy [NLVL];
    logic [3:0] cur_task;
    logic       cur_valid;
    logic       resel;

    prrs_pkg::t_cmd_item pending_actions [$];
    prrs_pkg::t_res_item expected_results [$];
    int        fail_count;
    int        cycle_count;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Link a task ahead of the last-run task of its level
    function automatic void link_task(input logic [3:0] t, input logic [4:0] lv);
        logic [3:0] h;
        logic [3:0] pv;
        if (!lvl_busy[lv]) begin
            lvl_last[lv] = t;
            nxt_link[t] = t;
            prv_link[t] = t;
            lvl_busy[lv] = 1'b1;
        end else begin
            h = lvl_last[lv];
            pv = prv_link[h];
            prv_link[t] = pv;
            nxt_link[t] = h;
            nxt_link[pv] = t;
            prv_link[h] = t;
        end
        is_ready[t] = 1'b1;
    endfunction

    // Unlink a ready task; return 1 when its level emptied
    function automatic bit unlink_task(input logic [3:0] t);
        logic [4:0] lv;
        logic [3:0] a;
        logic [3:0] b;
        bit emptied;
        lv = task_lvl[t];
        a = prv_link[t];
        b = nxt_link[t];
        emptied = 1'b0;
        nxt_link[a] = b;
        prv_link[b] = a;
        if (a == t) begin
            lvl_busy[lv] = 1'b0;
            emptied = 1'b1;
        end else if (lvl_last[lv] == t) begin
            lvl_last[lv] = a;
        end
        is_ready[t] = 1'b0;
        return emptied;
    endfunction

    // Pick the next running task; return status
    function automatic logic pick_next(input logic pv_valid, input logic [3:0] pv,
                                       inout prrs_pkg::t_res_item r);
        logic [3:0] n;
        bit have;
        n = '0;
        have = 1'b0;
        if (!resel && cur_valid) begin
            n = nxt_link[cur_task];
            if (is_used[n] && is_ready[n]) have = 1'b1;
        end
        if (!have) begin
            resel = 1'b0;
            for (int lv = NLVL - 1; lv >= 0; lv--) begin
                if (!have && lvl_busy[lv]) begin
                    n = nxt_link[lvl_last[lv]];
                    have = 1'b1;
                end
            end
        end
        if (!have) begin
            cur_valid = 1'b0;
            return 1'b1;
        end
        cur_task = n;
        cur_valid = 1'b1;
        lvl_last[task_lvl[n]] = n;
        if (!pv_valid || n != pv) begin
            r.switched = 1'b1;
            r.to_idle = (task_lvl[n] == 0);
        end
        return 1'b0;
    endfunction

    function automatic prrs_pkg::t_res_item predict_action(input prrs_pkg::t_cmd_item c);
        prrs_pkg::t_res_item r;
        logic pv_valid;
        logic [3:0] pv;
        pv_valid = cur_valid;
        pv = cur_task;
        r = '0;
        case (c.action)
            prrs_pkg::ACT_CREATE: begin
                if (is_used[c.task_id]) r.status = 1'b1;
                else begin
                    is_used[c.task_id] = 1'b1;
                    task_lvl[c.task_id] = c.task_priority;
                    if (!cur_valid) begin
                        cur_task = c.task_id;
                        cur_valid = 1'b1;
                    end else if (c.task_priority > task_lvl[cur_task]) begin
                        resel = 1'b1;
                    end
                    link_task(c.task_id, c.task_priority);
                end
            end
            prrs_pkg::ACT_DELETE: begin
                if (!is_used[c.task_id]) r.status = 1'b1;
                else begin
                    if (is_ready[c.task_id] && unlink_task(c.task_id)) resel = 1'b1;
                    is_used[c.task_id] = 1'b0;
                    if (cur_valid && cur_task == c.task_id)
                        r.status = pick_next(pv_valid, pv, r);
                end
            end
            prrs_pkg::ACT_BLOCK: begin
                if (!cur_valid || !is_ready[cur_task]) r.status = 1'b1;
                else begin
                    if (unlink_task(cur_task)) resel = 1'b1;
                    r.status = pick_next(pv_valid, pv, r);
                end
            end
            prrs_pkg::ACT_UNBLOCK: begin
                if (!is_used[c.task_id] || is_ready[c.task_id]) r.status = 1'b1;
                else begin
                    link_task(c.task_id, task_lvl[c.task_id]);
                    if (!cur_valid || task_lvl[c.task_id] > task_lvl[cur_task])
                        resel = 1'b1;
                end
            end
            prrs_pkg::ACT_SCHEDULE: r.status = pick_next(pv_valid, pv, r);
            default: r.status = 1'b1;
        endcase
        r.running_task = cur_valid ? cur_task : 4'd0;
        r.previous_task = pv_valid ? pv : 4'd0;
        return r;
    endfunction

    function automatic prrs_pkg::t_cmd_item make_action(input logic [2:0] a,
                                                        input logic [3:0] id,
                                                        input logic [4:0] pr);
        prrs_pkg::t_cmd_item c;
        c.action = a;
        c.task_id = id;
        c.task_priority = pr;
        return c;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 0;
        if (k < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: feed pending actions, with random gaps and one drain pause
    int  send_gap;
    int  sent_count;
    int  drain_at;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            send_gap <= 0;
        end else if (cmd_if.valid && !cmd_if.ready) begin
            // hold the offered item
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                expected_results.push_back(predict_action(cmd_if.data));
                sent_count = sent_count + 1;
            end
            if (send_gap > 0) begin
                cmd_if.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (sent_count == drain_at && expected_results.size() != 0) begin
                cmd_if.valid <= 1'b0;
            end else if (pending_actions.size() != 0) begin
                cmd_if.data <= pending_actions.pop_front();
                cmd_if.valid <= 1'b1;
                send_gap <= gap_len();
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) res_if.ready <= 1'b0;
        else if (cycle_count % 2000 < 700) res_if.ready <= 1'b1;
        else res_if.ready <= (gap_len() == 0);
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        prrs_pkg::t_res_item e;
        prrs_pkg::t_res_item g;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            g = res_if.data;
            if (expected_results.size() == 0) begin
                $error("unexpected result item %p", g);
                fail_count <= fail_count + 1;
            end else begin
                e = expected_results.pop_front();
                if (g.running_task !== e.running_task) begin
                    $error("running_task: expected %0d, got %0d", e.running_task, g.running_task);
                    fail_count <= fail_count + 1;
                end
                if (g.previous_task !== e.previous_task) begin
                    $error("previous_task: expected %0d, got %0d",
                           e.previous_task, g.previous_task);
                    fail_count <= fail_count + 1;
                end
                if (g.switched !== e.switched) begin
                    $error("switched: expected %0d, got %0d", e.switched, g.switched);
                    fail_count <= fail_count + 1;
                end
                if (g.to_idle !== e.to_idle) begin
                    $error("to_idle: expected %0d, got %0d", e.to_idle, g.to_idle);
                    fail_count <= fail_count + 1;
                end
                if (g.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, g.status);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        logic [2:0] a;
        int k;
        fail_count = 0;
        cycle_count = 0;
        sent_count = 0;
        drain_at = 400;
        cur_task = '0;
        cur_valid = 1'b0;
        resel = 1'b0;
        for (int i = 0; i < NTASK; i++) begin
            is_ready[i] = 1'b0;
            is_used[i] = 1'b0;
            nxt_link[i] = '0;
            prv_link[i] = '0;
            task_lvl[i] = '0;
        end
        for (int i = 0; i < NLVL; i++) begin
            lvl_busy[i] = 1'b0;
            lvl_last[i] = '0;
        end
        i_rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        res_if.ready = 1'b0;

        // Directed: empty cases, first task, extremes, preemption, idle, bad codes
        pending_actions.push_back(make_action(prrs_pkg::ACT_SCHEDULE, 4'd0, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_BLOCK, 4'd0, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_DELETE, 4'd15, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_UNBLOCK, 4'd3, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_CREATE, 4'd0, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_CREATE, 4'd0, 5'd31));
        pending_actions.push_back(make_action(prrs_pkg::ACT_CREATE, 4'd15, 5'd31));
        pending_actions.push_back(make_action(prrs_pkg::ACT_CREATE, 4'd5, 5'd31));
        pending_actions.push_back(make_action(prrs_pkg::ACT_SCHEDULE, 4'd0, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_SCHEDULE, 4'd0, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_UNBLOCK, 4'd5, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_BLOCK, 4'd0, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_BLOCK, 4'd0, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_DELETE, 4'd15, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_UNBLOCK, 4'd15, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_BLOCK, 4'd0, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_SCHEDULE, 4'd0, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_UNBLOCK, 4'd5, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_SCHEDULE, 4'd0, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_DELETE, 4'd0, 5'd0));
        pending_actions.push_back(make_action(prrs_pkg::ACT_DELETE, 4'd5, 5'd0));
        pending_actions.push_back(make_action(3'd5, 4'd10, 5'd10));
        pending_actions.push_back(make_action(3'd7, 4'd15, 5'd31));
        pending_actions.push_back(make_action(3'd6, 4'd0, 5'd0));

        // Random: mostly valid actions on a small priority spread, some wide
        for (int i = 0; i < 1130; i++) begin
            k = $urandom_range(0, 99);
            if (k < 25) a = prrs_pkg::ACT_CREATE;
            else if (k < 37) a = prrs_pkg::ACT_DELETE;
            else if (k < 52) a = prrs_pkg::ACT_BLOCK;
            else if (k < 67) a = prrs_pkg::ACT_UNBLOCK;
            else if (k < 97) a = prrs_pkg::ACT_SCHEDULE;
            else a = 3'($urandom_range(5, 7));
            pending_actions.push_back(make_action(a, 4'($urandom_range(0, 15)),
                ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 3))));
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_actions.size() == 0 && !cmd_if.valid);
        wait (expected_results.size() == 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
